// ===== src/byte_level_token_decoder_core_assert.svh =====
// Assertion macros for the byte-level token decoder.
// Taken in by the RTL files that carry checks; no other dependencies.
`ifndef BYTE_LEVEL_TOKEN_DECODER_CORE_ASSERT_SVH
`define BYTE_LEVEL_TOKEN_DECODER_CORE_ASSERT_SVH
`ifndef SYNTH
// Clocked check, masked while reset is held.
`define BLTD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that is live through reset as well.
`define BLTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BLTD_ASSERT(lbl, clk, rstn, prop, msg)
`define BLTD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/bltd_pkg.sv =====
// Shared types, constants and helper functions of the byte-level token decoder.
// No dependencies.
package bltd_pkg;

  localparam int unsigned PendDepth  = 4;
  localparam int unsigned PendIdxW   = $clog2(PendDepth);
  localparam int unsigned MaxResults = 12;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  typedef logic [7:0] byte_t;

  // Codepoint ranges
  localparam logic [20:0] CpMapLo   = 21'h000100;
  localparam logic [20:0] CpMapHi   = 21'h000143;
  localparam logic [20:0] CpIdALo   = 21'h000021;
  localparam logic [20:0] CpIdAHi   = 21'h00007E;
  localparam logic [20:0] CpIdBLo   = 21'h0000A1;
  localparam logic [20:0] CpIdBHi   = 21'h0000AC;
  localparam logic [20:0] CpIdCLo   = 21'h0000AE;
  localparam logic [20:0] CpIdCHi   = 21'h0000FF;
  localparam logic [20:0] CpSurLo   = 21'h00D800;
  localparam logic [20:0] CpSurHi   = 21'h00DFFF;
  localparam logic [20:0] CpMax     = 21'h10FFFF;

  // Replacement character U+FFFD as UTF-8
  localparam byte_t Repl0 = 8'hEF;
  localparam byte_t Repl1 = 8'hBF;
  localparam byte_t Repl2 = 8'hBD;

  // Soft-hyphen byte at the tail of the reverse table
  localparam byte_t RevTail = 8'hAD;

  typedef struct packed {
    logic [20:0] codepoint;
    logic        decode_error;
    logic        end_of_stream;
  } item_t;

  typedef struct packed {
    byte_t [MaxResults-1:0] bytes;
    logic  [CntW-1:0]       count;
  } res_t;

  typedef struct packed {
    byte_t [3:0] b;
    logic  [2:0] len;
  } enc_t;

  // GPT-2 reverse table for U+0100..U+0143, indexed by the low bits.
  function automatic byte_t reverse_map(input logic [6:0] idx);
    if (idx < 7'd33) begin
      return {1'b0, idx};
    end else if (idx < 7'd67) begin
      return {1'b0, idx} + 8'h5E;
    end else begin
      return RevTail;
    end
  endfunction

  function automatic logic [2:0] lead_len(input byte_t b);
    if (b[7:5] == 3'b110) begin
      return 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      return 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      return 3'd4;
    end else begin
      return 3'd1;
    end
  endfunction

  function automatic logic is_cont(input byte_t b);
    return b[7:6] == 2'b10;
  endfunction

  // Strict UTF-8 check of the first n bytes.
  function automatic logic seq_ok(input byte_t [3:0] v, input logic [2:0] n);
    logic ok;
    ok = 1'b1;
    case (n)
      3'd1: ok = v[0] < 8'h80;
      3'd2: ok = (v[0] >= 8'hC2) && is_cont(v[1]);
      3'd3: ok = !(v[0] == 8'hE0 && v[1] < 8'hA0) && !(v[0] == 8'hED && v[1] > 8'h9F) &&
                 is_cont(v[1]) && is_cont(v[2]);
      default: ok = (v[0] <= 8'hF4) && !(v[0] == 8'hF0 && v[1] < 8'h90) &&
                    !(v[0] == 8'hF4 && v[1] > 8'h8F) &&
                    is_cont(v[1]) && is_cont(v[2]) && is_cont(v[3]);
    endcase
    return ok;
  endfunction

  function automatic enc_t encode_cp(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.b[0] = cp[7:0];
      e.len  = 3'd1;
    end else if (cp < 21'h800) begin
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
      e.len  = 3'd2;
    end else if (cp < 21'h10000) begin
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
      e.len  = 3'd3;
    end else begin
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
      e.len  = 3'd4;
    end
    return e;
  endfunction

endpackage

// ===== src/bltd_in_if.sv =====
// Input channel: one codepoint word with its flags, valid/ready handshake.
// Depends on nothing.
interface bltd_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] codepoint;
  logic        decode_error;
  logic        end_of_stream;

  modport source (output valid, codepoint, decode_error, end_of_stream, input ready);
  modport sink   (input valid, codepoint, decode_error, end_of_stream, output ready);
endinterface

// ===== src/bltd_out_if.sv =====
// Output channel: one byte word per handshake, valid/ready.
// Depends on bltd_pkg.
interface bltd_out_if;
  logic              valid;
  logic              ready;
  bltd_pkg::byte_t   out_byte;
  logic              last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ===== src/byte_level_token_decoder_core.sv =====
// Byte-level token decoder: a word passes the input register, then the result
// register, before its first output byte. With the output always ready an input
// word is taken every cycle while each word yields at most one byte; a word of N
// bytes stays in the result register, one output byte per cycle, and stalls the
// input once the input register is full. Reset clears the valid flags and the
// pending count. Depends on bltd_pkg, bltd_in_if, bltd_out_if, bltd_step, bltd_out.
`include "byte_level_token_decoder_core_assert.svh"

module byte_level_token_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  bltd_in_if.sink     in_i,
  bltd_out_if.source  out_o
);

  // Input register
  logic             item_valid_q;
  bltd_pkg::item_t  item_q;

  // Pending UTF-8 bytes (store needs no reset: only entries below the count
  // are ever read)
  logic [bltd_pkg::PendIdxW-1:0]                pend_cnt_q, pend_cnt_d;
  bltd_pkg::byte_t [bltd_pkg::PendDepth-1:0]    pend_store_q, pend_store_d;

  bltd_pkg::res_t res;
  logic           res_ready;
  logic           step_take;

  // A word moves from the input register into the result register whenever
  // the serializer is empty or emitting its last byte; the pending state is
  // committed at the same edge.
  assign step_take = item_valid_q && res_ready;
  assign in_i.ready = !item_valid_q || step_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      pend_cnt_q   <= '0;
    end else begin
      if (in_i.ready) begin
        item_valid_q <= in_i.valid;
      end
      if (step_take) begin
        pend_cnt_q <= pend_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.codepoint     <= in_i.codepoint;
      item_q.decode_error  <= in_i.decode_error;
      item_q.end_of_stream <= in_i.end_of_stream;
    end
    if (step_take) begin
      pend_store_q <= pend_store_d;
    end
  end

  // All per-word decoding in one combinational pass
  bltd_step u_step (
    .item_i       (item_q),
    .pend_cnt_i   (pend_cnt_q),
    .pend_store_i (pend_store_q),
    .res_o        (res),
    .pend_cnt_o   (pend_cnt_d),
    .pend_store_o (pend_store_d)
  );

  // Result register and byte serializer
  bltd_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step_take),
    .res_i   (res),
    .ready_o (res_ready),
    .out_o   (out_o)
  );

  `BLTD_ASSERT(a_eos_clears_pending, clk_i, rst_ni,
               (step_take && item_q.end_of_stream) |=> (pend_cnt_q == '0),
               "pending bytes survive end of stream")
  `BLTD_ASSERT(a_in_lands, clk_i, rst_ni,
               (in_i.valid && in_i.ready) |=> item_valid_q,
               "accepted word not held")
  `BLTD_ASSERT_ALWAYS(a_reset_clears, clk_i,
                      !rst_ni |=> (!item_valid_q && pend_cnt_q == '0),
                      "reset left state behind")

endmodule

// ===== src/bltd_step.sv =====
// Combinational per-word step: classifies the codepoint, updates the pending
// bytes and builds the full result list. Depends on bltd_pkg.
module bltd_step (
  input  bltd_pkg::item_t                              item_i,
  input  logic [bltd_pkg::PendIdxW-1:0]                pend_cnt_i,
  input  bltd_pkg::byte_t [bltd_pkg::PendDepth-1:0]    pend_store_i,
  output bltd_pkg::res_t                               res_o,
  output logic [bltd_pkg::PendIdxW-1:0]                pend_cnt_o,
  output bltd_pkg::byte_t [bltd_pkg::PendDepth-1:0]    pend_store_o
);

  logic                                     is_bad, is_map, is_id, pend;
  bltd_pkg::byte_t                          map_b;
  bltd_pkg::byte_t [bltd_pkg::PendDepth-1:0] view;
  logic [bltd_pkg::PendIdxW:0]              cnt_new;
  logic                                     emit;
  bltd_pkg::byte_t [bltd_pkg::MaxResults-1:0] repl;
  bltd_pkg::enc_t                           enc;
  logic [20:0]                              cp;

  assign cp = item_i.codepoint;

  always_comb begin
    is_bad = item_i.decode_error || (cp >= bltd_pkg::CpSurLo && cp <= bltd_pkg::CpSurHi) ||
             (cp > bltd_pkg::CpMax);
    is_map = cp >= bltd_pkg::CpMapLo && cp <= bltd_pkg::CpMapHi;
    is_id  = (cp >= bltd_pkg::CpIdALo && cp <= bltd_pkg::CpIdAHi) ||
             (cp >= bltd_pkg::CpIdBLo && cp <= bltd_pkg::CpIdBHi) ||
             (cp >= bltd_pkg::CpIdCLo && cp <= bltd_pkg::CpIdCHi);
    pend   = pend_cnt_i != '0;
    map_b  = is_map ? bltd_pkg::reverse_map(cp[6:0]) : cp[7:0];

    // pending bytes with the new byte dropped in at the fill position
    for (int i = 0; i < bltd_pkg::PendDepth; i++) begin
      view[i] = (pend_cnt_i == bltd_pkg::PendIdxW'(i)) ? map_b : pend_store_i[i];
    end
    cnt_new = {1'b0, pend_cnt_i} + 1'b1;
    // view[0] is the lead byte, new or old
    emit    = cnt_new >= bltd_pkg::lead_len(view[0]);
    enc     = bltd_pkg::encode_cp(cp);

    for (int i = 0; i < bltd_pkg::MaxResults; i++) begin
      repl[i] = (i % 3 == 0) ? bltd_pkg::Repl0 :
                (i % 3 == 1) ? bltd_pkg::Repl1 : bltd_pkg::Repl2;
    end

    res_o.bytes  = repl;
    res_o.count  = '0;
    pend_cnt_o   = '0;
    pend_store_o = view;

    if (item_i.end_of_stream) begin
      res_o.count = pend ? bltd_pkg::CntW'(3) : '0;
    end else if (is_bad) begin
      res_o.count = pend ? bltd_pkg::CntW'(6) : bltd_pkg::CntW'(3);
    end else if (is_map || is_id) begin
      if (!emit) begin
        pend_cnt_o = cnt_new[bltd_pkg::PendIdxW-1:0];
      end else if (bltd_pkg::seq_ok(view, cnt_new)) begin
        for (int i = 0; i < bltd_pkg::PendDepth; i++) begin
          res_o.bytes[i] = view[i];
        end
        res_o.count = bltd_pkg::CntW'(cnt_new);
      end else begin
        // one replacement per byte of the bad sequence
        res_o.count = bltd_pkg::CntW'(cnt_new) + (bltd_pkg::CntW'(cnt_new) << 1);
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (pend) begin
          res_o.bytes[i+3] = enc.b[i];
        end else begin
          res_o.bytes[i] = enc.b[i];
        end
      end
      res_o.count = (pend ? bltd_pkg::CntW'(3) : '0) + bltd_pkg::CntW'(enc.len);
    end
  end

endmodule

// ===== src/bltd_out.sv =====
// Result register and byte serializer for the output channel.
// Depends on bltd_pkg, bltd_out_if and the assertion header.
`include "byte_level_token_decoder_core_assert.svh"

module bltd_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  bltd_pkg::res_t     res_i,
  output logic               ready_o,
  bltd_out_if.source         out_o
);

  logic                       res_valid_q;
  bltd_pkg::res_t             res_q;
  logic [bltd_pkg::CntW-1:0]  idx_q;
  logic                       fire, last;

  assign last            = idx_q == (res_q.count - bltd_pkg::CntW'(1));
  assign fire            = out_o.valid && out_o.ready;
  assign ready_o         = !res_valid_q || (fire && last);
  assign out_o.valid     = res_valid_q;
  assign out_o.out_byte  = res_q.bytes[idx_q];
  assign out_o.last_byte = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load_i) begin
      res_valid_q <= res_i.count != '0;
      idx_q       <= '0;
    end else if (fire) begin
      if (last) begin
        res_valid_q <= 1'b0;
      end
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  `BLTD_ASSERT(a_idx_in_range, clk_i, rst_ni, res_valid_q |-> (idx_q < res_q.count), "byte index past result count")
  `BLTD_ASSERT(a_load_when_free, clk_i, rst_ni, load_i |-> ready_o, "result loaded over live result")
  `BLTD_ASSERT(a_idx_steps, clk_i, rst_ni, (fire && !last && !load_i) |=> (idx_q == $past(idx_q) + 1'b1), "byte index did not advance")

endmodule
